[sv/ecgf_pkg.sv]
// shared types, constants and the control program of the ecg notch/high-pass filter
package ecgf_pkg;

  localparam int unsigned WINDOW      = 1000;
  localparam int unsigned NOTCH_ORDER = 2;
  localparam bit          ORDER_ONE   = (NOTCH_ORDER < 2);

  localparam int unsigned CODE_W    = 12;
  localparam int unsigned VOLTS_W   = 18;
  localparam int unsigned COEF_W    = 16;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned CNT_W     = 10;
  localparam int unsigned NUM_REGS  = 8;
  localparam int unsigned REG_IDX_W = 3;
  localparam int unsigned PC_W      = 4;
  localparam int unsigned OPND_W    = 33;
  localparam int unsigned PROD_W    = 49;
  localparam int unsigned ACC_W     = 40;

  // volts = floor((code * 264 + 2) / 5) via reciprocal multiply
  localparam int unsigned  VNUM_W     = 21;
  localparam int unsigned  RECIP_W    = 22;
  localparam int unsigned  DIV5_SHIFT = 24;
  localparam logic [RECIP_W-1:0] DIV5_RECIP = 22'd3355444;

  localparam logic signed [COEF_W-1:0] COEF_RESET [NUM_REGS] = '{
    16'sd16384, -16'sd23170, 16'sd16384, -16'sd30274,
    16'sd14932, 16'sd16384, -16'sd16384, -16'sd16302
  };

  typedef enum logic [3:0] {
    COEF_NOTCH_B0 = 4'd0,
    COEF_NOTCH_B1 = 4'd1,
    COEF_NOTCH_B2 = 4'd2,
    COEF_NOTCH_A1 = 4'd3,
    COEF_NOTCH_A2 = 4'd4,
    COEF_HP_B0    = 4'd5,
    COEF_HP_B1    = 4'd6,
    COEF_HP_A1    = 4'd7,
    COEF_HUNDRED  = 4'd8
  } coef_sel_t;

  typedef enum logic [1:0] {
    OPND_X = 2'd0,
    OPND_Y = 2'd1,
    OPND_Z = 2'd2
  } opnd_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD = 2'd0,
    ACC_LOAD = 2'd1,
    ACC_SUB  = 2'd2
  } acc_op_t;

  typedef enum logic [2:0] {
    WB_NONE = 3'd0,
    WB_Y    = 3'd1,
    WB_S0   = 3'd2,
    WB_S1   = 3'd3,
    WB_Z    = 3'd4,
    WB_H0   = 3'd5
  } wb_dst_t;

  typedef enum logic [1:0] {
    ADD_NONE = 2'd0,
    ADD_S0   = 2'd1,
    ADD_S1   = 2'd2,
    ADD_H0   = 2'd3
  } addend_sel_t;

  typedef enum logic [1:0] {
    JMP_NONE   = 2'd0,
    JMP_ALWAYS = 2'd1,
    JMP_ORDER1 = 2'd2
  } jump_t;

  typedef struct packed {
    coef_sel_t         coef;
    opnd_sel_t         opnd;
    logic              round;
    acc_op_t           acc;
    wb_dst_t           wb;
    addend_sel_t       addend;
    jump_t             jump;
    logic [PC_W-1:0]   target;
    logic              last;
  } ctrl_t;

  typedef struct packed {
    logic  load;
    logic  step;
    ctrl_t uc;
  } dp_ctrl_t;

  localparam logic [PC_W-1:0] STEP_HP_OUT = 4'd9;
  localparam logic [PC_W-1:0] STEP_ORD1   = 4'd14;

  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t w;
    w = '{coef: COEF_NOTCH_B0, opnd: OPND_X, round: 1'b1, acc: ACC_HOLD, wb: WB_NONE,
          addend: ADD_NONE, jump: JMP_NONE, target: '0, last: 1'b0};
    case (pc)
      4'd0: begin
        w.coef = COEF_NOTCH_B0; w.opnd = OPND_X;
      end
      4'd1: begin
        w.acc = ACC_LOAD;
      end
      4'd2: begin
        w.wb = WB_Y; w.addend = ADD_S0;
        w.coef = COEF_NOTCH_B1; w.opnd = OPND_X;
      end
      4'd3: begin
        w.coef = COEF_NOTCH_A1; w.opnd = OPND_Y; w.acc = ACC_LOAD;
      end
      4'd4: begin
        w.coef = COEF_NOTCH_B2; w.opnd = OPND_X; w.acc = ACC_SUB;
        w.jump = JMP_ORDER1; w.target = STEP_ORD1;
      end
      4'd5: begin
        w.coef = COEF_NOTCH_A2; w.opnd = OPND_Y;
        w.wb = WB_S0; w.addend = ADD_S1; w.acc = ACC_LOAD;
      end
      4'd6: begin
        w.acc = ACC_SUB;
      end
      4'd7: begin
        w.wb = WB_S1; w.coef = COEF_HP_B0; w.opnd = OPND_Y;
      end
      4'd8: begin
        w.acc = ACC_LOAD;
      end
      4'd9: begin
        w.wb = WB_Z; w.addend = ADD_H0;
        w.coef = COEF_HP_B1; w.opnd = OPND_Y;
      end
      4'd10: begin
        w.coef = COEF_HP_A1; w.opnd = OPND_Z; w.acc = ACC_LOAD;
      end
      4'd11: begin
        w.coef = COEF_HUNDRED; w.opnd = OPND_Z; w.round = 1'b0; w.acc = ACC_SUB;
      end
      4'd12: begin
        w.wb = WB_H0; w.acc = ACC_LOAD;
      end
      4'd13: begin
        w.last = 1'b1;
      end
      4'd14: begin
        w.wb = WB_S0; w.coef = COEF_HP_B0; w.opnd = OPND_Y;
      end
      4'd15: begin
        w.acc = ACC_LOAD; w.jump = JMP_ALWAYS; w.target = STEP_HP_OUT;
      end
      default: begin
        w.last = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage

[sv/ecg_notch_highpass_filter_unit.sv]
// top level of the ecg notch and high-pass filter with its program sequencer
// Converts each 12-bit converter code to volts (unsigned Q2.16), runs it through a
// second-order notch and a first-order high-pass section (transposed direct form II,
// Q2.14 coefficients from the write port, Q15.16 saturating values) and returns the
// voltage, the filtered value, the filtered value times 100 and a flag on the last
// sample of every window. One multiplier is shared by all filter products, stepped by a
// 16-word control program; an item runs the full program with the second-order notch
// and jumps past the second notch state with a first-order notch, and the last step
// waits while the previous result is still held in the output register.
// in_stall is high while a program runs. Coefficients reset to their default values.
module ecg_notch_highpass_filter_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [ecgf_pkg::REG_IDX_W-1:0]       cfg_index,
  input  logic [ecgf_pkg::COEF_W-1:0]          cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [ecgf_pkg::CODE_W-1:0]          adc_code,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [ecgf_pkg::VOLTS_W-1:0]         volts,
  output logic signed [ecgf_pkg::DATA_W-1:0]   filtered,
  output logic signed [ecgf_pkg::DATA_W-1:0]   scaled,
  output logic                                 window_end
);
  import ecgf_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t                    state;
  logic [PC_W-1:0]           pc, pc_next;
  logic [CNT_W-1:0]          count;
  logic [CNT_W:0]            cnt_inc;
  logic                      wrap;
  ctrl_t                     uc;
  dp_ctrl_t                  dp;
  logic                      accept, advance, finish;
  logic [VOLTS_W-1:0]        x_val;
  logic signed [DATA_W-1:0]  z_val, sat_val;

  always_comb begin
    uc       = ucode(pc);
    in_stall = (state != ST_IDLE);
    accept   = in_valid && !in_stall;
    advance  = (state == ST_RUN) && !(uc.last && out_valid && out_stall);
    finish   = advance && uc.last;
    unique case (uc.jump)
      JMP_ALWAYS: pc_next = uc.target;
      JMP_ORDER1: pc_next = ORDER_ONE ? uc.target : pc + PC_W'(1);
      default:    pc_next = pc + PC_W'(1);
    endcase
    cnt_inc = {1'b0, count} + (CNT_W+1)'(1);
    wrap    = (cnt_inc >= (CNT_W+1)'(WINDOW));
    dp      = '{load: accept, step: advance, uc: uc};
  end

  ecgf_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .adc_code  (adc_code),
    .dp        (dp),
    .x_val     (x_val),
    .z_val     (z_val),
    .sat_val   (sat_val)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pc        <= '0;
      out_valid <= 1'b0;
      count     <= '0;
    end else begin
      if (accept) begin
        state <= ST_RUN;
        pc    <= '0;
      end else if (finish) begin
        state <= ST_IDLE;
      end else if (advance) begin
        pc <= pc_next;
      end
      if (finish) begin
        out_valid <= 1'b1;
        count     <= wrap ? '0 : cnt_inc[CNT_W-1:0];
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      volts      <= x_val;
      filtered   <= z_val;
      scaled     <= sat_val;
      window_end <= wrap;
    end
  end

`ifndef SYNTHESIS
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_RUN) && (pc == '0))
    else $error("accepted transaction did not start the program");

  a_last_holds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) && uc.last && out_valid && out_stall |=> (state == ST_RUN) && $stable(pc))
    else $error("program left its last step while the result register was full");

  a_finish_delivers: assert property (@(posedge clk) disable iff (rst)
    finish |=> out_valid && (state == ST_IDLE))
    else $error("finished program did not present a result");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (CNT_W+1)'(count) < (CNT_W+1)'(WINDOW))
    else $error("sample counter reached the window length");
`endif

endmodule

[sv/ecgf_datapath.sv]
// shared multiply-accumulate datapath with coefficient bank and filter state
module ecgf_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [ecgf_pkg::REG_IDX_W-1:0]       cfg_index,
  input  logic [ecgf_pkg::COEF_W-1:0]          cfg_data,
  input  logic [ecgf_pkg::CODE_W-1:0]          adc_code,
  input  ecgf_pkg::dp_ctrl_t                   dp,
  output logic [ecgf_pkg::VOLTS_W-1:0]         x_val,
  output logic signed [ecgf_pkg::DATA_W-1:0]   z_val,
  output logic signed [ecgf_pkg::DATA_W-1:0]   sat_val
);
  import ecgf_pkg::*;

  localparam logic signed [PROD_W-1:0] ROUND_BIAS = PROD_W'(8192);
  localparam int unsigned FRAC_SHIFT = 14;
  localparam logic signed [COEF_W-1:0] HUNDRED = 16'sd100;

  logic signed [COEF_W-1:0]  coef_bank [NUM_REGS];
  logic [VOLTS_W-1:0]        x_q;
  logic signed [DATA_W-1:0]  y_q, z_q, s0_q, s1_q, h0_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic                      round_q;
  logic signed [ACC_W-1:0]   acc_q;

  logic [VNUM_W-1:0]             v_num;
  logic [VNUM_W+RECIP_W-1:0]     v_prod;
  logic signed [COEF_W-1:0]      coef_op;
  logic signed [OPND_W-1:0]      opnd_op;
  logic signed [PROD_W-1:0]      prod_d;
  logic signed [PROD_W-1:0]      rnd_sum, rnd_shift;
  logic signed [ACC_W-1:0]       term;
  logic signed [DATA_W-1:0]      addend;
  logic signed [ACC_W-1:0]       wb_sum;

  // converter code to volts
  always_comb begin
    v_num  = (VNUM_W'(adc_code) << 8) + (VNUM_W'(adc_code) << 3) + VNUM_W'(2);
    v_prod = (VNUM_W+RECIP_W)'(v_num) * (VNUM_W+RECIP_W)'(DIV5_RECIP);
  end

  // multiplier operands
  always_comb begin
    if (dp.uc.coef == COEF_HUNDRED) begin
      coef_op = HUNDRED;
    end else begin
      coef_op = coef_bank[dp.uc.coef[REG_IDX_W-1:0]];
    end
    unique case (dp.uc.opnd)
      OPND_Y:  opnd_op = {y_q[DATA_W-1], y_q};
      OPND_Z:  opnd_op = {z_q[DATA_W-1], z_q};
      default: opnd_op = signed'({{(OPND_W-VOLTS_W){1'b0}}, x_q});
    endcase
    prod_d = coef_op * opnd_op;
  end

  // rounding of the registered product
  always_comb begin
    rnd_sum   = prod_q + ROUND_BIAS;
    rnd_shift = rnd_sum >>> FRAC_SHIFT;
    term      = round_q ? rnd_shift[ACC_W-1:0] : prod_q[ACC_W-1:0];
  end

  // write-back with saturation to 32 bits
  always_comb begin
    unique case (dp.uc.addend)
      ADD_S0:  addend = s0_q;
      ADD_S1:  addend = s1_q;
      ADD_H0:  addend = h0_q;
      default: addend = '0;
    endcase
    wb_sum = acc_q + {{(ACC_W-DATA_W){addend[DATA_W-1]}}, addend};
    if ((&wb_sum[ACC_W-1:DATA_W-1]) || !(|wb_sum[ACC_W-1:DATA_W-1])) begin
      sat_val = wb_sum[DATA_W-1:0];
    end else if (wb_sum[ACC_W-1]) begin
      sat_val = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      sat_val = {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        coef_bank[i] <= COEF_RESET[i];
      end
    end else if (cfg_write) begin
      coef_bank[cfg_index] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_q <= '0;
      s1_q <= '0;
      h0_q <= '0;
    end else if (dp.step) begin
      unique case (dp.uc.wb)
        WB_S0:   s0_q <= sat_val;
        WB_S1:   s1_q <= sat_val;
        WB_H0:   h0_q <= sat_val;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (dp.load) begin
      x_q <= v_prod[DIV5_SHIFT+VOLTS_W-1:DIV5_SHIFT];
    end
    if (dp.step) begin
      prod_q  <= prod_d;
      round_q <= dp.uc.round;
      unique case (dp.uc.acc)
        ACC_LOAD: acc_q <= term;
        ACC_SUB:  acc_q <= acc_q - term;
        default:  ;
      endcase
      unique case (dp.uc.wb)
        WB_Y:    y_q <= sat_val;
        WB_Z:    z_q <= sat_val;
        default: ;
      endcase
    end
  end

  assign x_val = x_q;
  assign z_val = z_q;

endmodule

[dv/ecg_filter_monitor.sv]
// transaction monitor that predicts and checks every result of the ecg filter unit
`timescale 1ns / 1ps

module ecg_filter_monitor (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [ecgf_pkg::REG_IDX_W-1:0]       cfg_index,
  input  logic [ecgf_pkg::COEF_W-1:0]          cfg_data,
  input  logic                                 in_valid,
  input  logic                                 in_stall,
  input  logic [ecgf_pkg::CODE_W-1:0]          adc_code,
  input  logic                                 out_valid,
  input  logic                                 out_stall,
  input  logic [ecgf_pkg::VOLTS_W-1:0]         volts,
  input  logic signed [ecgf_pkg::DATA_W-1:0]   filtered,
  input  logic signed [ecgf_pkg::DATA_W-1:0]   scaled,
  input  logic                                 window_end,
  output int                                   fail_count,
  output int                                   outstanding
);
  import ecgf_pkg::*;

  typedef struct {
    logic [VOLTS_W-1:0]       volts;
    logic signed [DATA_W-1:0] filtered;
    logic signed [DATA_W-1:0] scaled;
    logic                     window_end;
  } filter_out_t;

  localparam longint WORD_MAX = 64'sd2147483647;
  localparam longint WORD_MIN = -64'sd2147483648;

  logic signed [COEF_W-1:0] coef [NUM_REGS];
  logic signed [DATA_W-1:0] notch_d0, notch_d1, hp_d0;
  logic [CNT_W-1:0]         window_count;
  filter_out_t              expected_samples [$];
  int                       result_count;

  function automatic longint sat_word(input longint v);
    if (v > WORD_MAX) return WORD_MAX;
    if (v < WORD_MIN) return WORD_MIN;
    return v;
  endfunction

  // q2.14 coefficient times q15.16 value, rounded back to q15.16
  function automatic longint coef_mul(input logic signed [COEF_W-1:0] c, input longint v);
    longint p;
    p = longint'(c) * v + 64'sd8192;
    return p >>> 14;
  endfunction

  function automatic filter_out_t filter_sample(input logic [CODE_W-1:0] code);
    filter_out_t r;
    longint      x, y, z, sc;
    int unsigned v;
    v = (int'(code) * 264 + 2) / 5;
    x = longint'(v);
    y = sat_word(coef_mul(coef[COEF_NOTCH_B0], x) + longint'(notch_d0));
    if (NOTCH_ORDER >= 2) begin
      notch_d0 = DATA_W'(sat_word(coef_mul(coef[COEF_NOTCH_B1], x)
                 - coef_mul(coef[COEF_NOTCH_A1], y) + longint'(notch_d1)));
      notch_d1 = DATA_W'(sat_word(coef_mul(coef[COEF_NOTCH_B2], x)
                 - coef_mul(coef[COEF_NOTCH_A2], y)));
    end else begin
      notch_d0 = DATA_W'(sat_word(coef_mul(coef[COEF_NOTCH_B1], x)
                 - coef_mul(coef[COEF_NOTCH_A1], y)));
    end
    z = sat_word(coef_mul(coef[COEF_HP_B0], y) + longint'(hp_d0));
    hp_d0 = DATA_W'(sat_word(coef_mul(coef[COEF_HP_B1], y) - coef_mul(coef[COEF_HP_A1], z)));
    sc = sat_word(z * 100);
    r.window_end = (int'(window_count) + 1 >= int'(WINDOW));
    window_count = r.window_end ? '0 : window_count + 1'b1;
    r.volts    = VOLTS_W'(v);
    r.filtered = DATA_W'(z);
    r.scaled   = DATA_W'(sc);
    return r;
  endfunction

  always @(posedge clk) begin
    filter_out_t want;
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) coef[i] = COEF_RESET[i];
      notch_d0 = '0;
      notch_d1 = '0;
      hp_d0 = '0;
      window_count = '0;
      expected_samples.delete();
      result_count = 0;
      fail_count <= 0;
      outstanding <= 0;
    end else begin
      if (cfg_write) coef[cfg_index] = cfg_data;
      if (in_valid && !in_stall) expected_samples.push_back(filter_sample(adc_code));
      if (out_valid && !out_stall) begin
        if (expected_samples.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected result %0d: volts %0d filtered %0d scaled %0d window_end %0b",
                     result_count, volts, filtered, scaled, window_end);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_samples.pop_front();
          if (want.volts !== volts || want.filtered !== filtered ||
              want.scaled !== scaled || want.window_end !== window_end) begin
            if (fail_count < 10) begin
              $display("mismatch on result %0d (exp/got): volts %0d/%0d filtered %0d/%0d",
                       result_count, want.volts, volts, want.filtered, filtered);
              $display("  scaled %0d/%0d window_end %0b/%0b",
                       want.scaled, scaled, want.window_end, window_end);
            end
            fail_count <= fail_count + 1;
          end
        end
        result_count++;
      end
      outstanding <= expected_samples.size();
    end
  end

endmodule

[dv/ecg_notch_highpass_filter_unit_tb.sv]
// testbench top: stimulus, handshake idling and verdict for the ecg filter unit
`timescale 1ns / 1ps

module ecg_notch_highpass_filter_unit_tb;
  import ecgf_pkg::*;

  typedef enum {
    PLAN_DEFAULT,
    PLAN_MAX,
    PLAN_MIN,
    PLAN_RANDOM,
    PLAN_MIXED
  } coef_plan_t;

  logic                       clk;
  logic                       rst;
  logic                       cfg_write;
  logic [REG_IDX_W-1:0]       cfg_index;
  logic [COEF_W-1:0]          cfg_data;
  logic                       in_valid;
  logic                       in_stall;
  logic [CODE_W-1:0]          adc_code;
  logic                       out_valid;
  logic                       out_stall;
  logic [VOLTS_W-1:0]         volts;
  logic signed [DATA_W-1:0]   filtered;
  logic signed [DATA_W-1:0]   scaled;
  logic                       window_end;
  int                         fail_count;
  int                         outstanding;

  int                         idle_pct;
  int                         stall_pct;
  logic                       hold_off;
  logic                       pressure_go;
  int                         walk_code;
  logic signed [COEF_W-1:0]   coef_plan [NUM_REGS];

  ecg_notch_highpass_filter_unit dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .adc_code   (adc_code),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .volts      (volts),
    .filtered   (filtered),
    .scaled     (scaled),
    .window_end (window_end)
  );

  ecg_filter_monitor u_monitor (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .adc_code    (adc_code),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .volts       (volts),
    .filtered    (filtered),
    .scaled      (scaled),
    .window_end  (window_end),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      out_stall <= hold_off || (int'($urandom_range(99)) < stall_pct);
    end
  end

  // long receiver hold-off so the unit fills and backs up its input
  initial begin
    hold_off = 1'b0;
    wait (pressure_go);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (300) @(posedge clk);
    hold_off <= 1'b0;
  end

  function automatic logic [CODE_W-1:0] next_code();
    int r;
    r = $urandom_range(99);
    if (r < 45) begin
      walk_code = $urandom_range(4095);
    end else if (r < 75) begin
      walk_code = walk_code + int'($urandom_range(128)) - 64;
      if (walk_code < 0) walk_code = 0;
      if (walk_code > 4095) walk_code = 4095;
    end else if (r < 90) begin
      walk_code = $urandom_range(1) ? 4095 : 0;
    end else begin
      walk_code = $urandom_range(1) ? $urandom_range(4095, 4080) : $urandom_range(15);
    end
    return CODE_W'(walk_code);
  endfunction

  task automatic send_code(input logic [CODE_W-1:0] code);
    while (int'($urandom_range(99)) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    adc_code <= code;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_coefs(input coef_plan_t plan);
    int pick;
    for (int i = 0; i < NUM_REGS; i++) begin
      pick = $urandom_range(5);
      case (plan)
        PLAN_DEFAULT: coef_plan[i] = COEF_RESET[i];
        PLAN_MAX:     coef_plan[i] = 16'sh7FFF;
        PLAN_MIN:     coef_plan[i] = 16'sh8000;
        PLAN_RANDOM:  coef_plan[i] = COEF_W'($urandom);
        default: begin
          case (pick)
            0:       coef_plan[i] = 16'sh7FFF;
            1:       coef_plan[i] = 16'sh8000;
            2:       coef_plan[i] = '0;
            3:       coef_plan[i] = 16'sd16384;
            4:       coef_plan[i] = -16'sd16384;
            default: coef_plan[i] = COEF_W'($urandom);
          endcase
        end
      endcase
    end
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= REG_IDX_W'(i);
      cfg_data  <= coef_plan[i];
      @(posedge clk);
    end
    cfg_write <= 1'b0;
  endtask

  task automatic run_phase(input coef_plan_t plan, input int idle, input int stall,
                           input int count, input bit pressure);
    wait_drained();
    write_coefs(plan);
    idle_pct = idle;
    stall_pct = stall;
    if (pressure) pressure_go = 1'b1;
    for (int n = 0; n < count; n++) send_code(next_code());
    in_valid <= 1'b0;
  endtask

  localparam logic [CODE_W-1:0] DIRECTED_CODES [22] = '{
    12'd0, 12'd4095, 12'd0, 12'd4095, 12'd1, 12'd4094, 12'd2048, 12'd2047,
    12'hAAA, 12'h555, 12'd2, 12'd3, 12'd4095, 12'd4095, 12'd4095, 12'd4095,
    12'd4095, 12'd4095, 12'd0, 12'd0, 12'd0, 12'd0
  };

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    adc_code = '0;
    idle_pct = 0;
    stall_pct = 0;
    pressure_go = 1'b0;
    walk_code = 2048;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (DIRECTED_CODES[i]) send_code(DIRECTED_CODES[i]);
    in_valid <= 1'b0;

    run_phase(PLAN_MAX,     70,  0, 200, 1'b0);
    run_phase(PLAN_MIN,      0, 70, 200, 1'b0);
    run_phase(PLAN_RANDOM,  27, 27, 200, 1'b0);
    run_phase(PLAN_DEFAULT,  0,  0, 200, 1'b1);
    run_phase(PLAN_MIXED,   70,  0, 200, 1'b0);
    run_phase(PLAN_DEFAULT, 27, 27, 200, 1'b0);

    wait_drained();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && outstanding == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
